// ----- rtl/kmhrb_pkg.sv -----
// shared types, codes and defaults for the key matrix hid report builder
package kmhrb_pkg;

  localparam int ROWS_DEF  = 8;
  localparam int COLS_DEF  = 16;
  localparam int SLOTS_DEF = 6;

  localparam int CODE_W     = 8;
  localparam int EDGE_DEPTH = 256;
  localparam int EDGE_W     = 8;
  localparam int OUT_SLOTS  = 6;
  localparam int LEVELS_W   = 16;

  // key history and edge list codes: bit 0 current level, bit 1 last level
  localparam logic [1:0] EDGE_NONE    = 2'b00;
  localparam logic [1:0] EDGE_PRESS   = 2'b01;
  localparam logic [1:0] EDGE_RELEASE = 2'b10;

  // modifier usages 0xE0..0xE7 share this five-bit prefix
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SCAN   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_UPD,
    ST_DRAIN,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic              clr;
    logic              vld;
    logic              press;
    logic [CODE_W-1:0] code;
  } slot_cmd_t;

endpackage

// ----- rtl/key_matrix_hid_report_builder.sv -----
// top level: keyboard matrix scanner and 6-key hid report builder
// Usage:
//   Commands enter on start when busy is low; operation picks the command.
//   Load keymap entry: written in the accept cycle, busy stays low, so loads
//     may follow back to back. Out-of-range row or column is ignored.
//   Scan row: busy while, key by key, the history and keymap entries are
//     read in ST_SCAN_RD and the history entry is written in ST_SCAN_WR.
//   Update report: busy while the edge list memory is read once
//     per cycle over a release pass and then a press pass, each hit applied
//     to the slot table. When a slot changed, done pulses for one cycle with
//     modifier_bits and slot_0..slot_5 valid in that cycle; otherwise no
//     transfer happens. The receiver cannot stall the result.
//   Clear update list: busy while one edge list entry per cycle is zeroed.
//   Reset: rst clears the slots and modifiers, then a clearing pass zeroes
//     key history and edge list while busy is high. Keymap contents are
//     undefined until loaded.
module key_matrix_hid_report_builder #(
  parameter int ROWS  = kmhrb_pkg::ROWS_DEF,
  parameter int COLS  = kmhrb_pkg::COLS_DEF,
  parameter int SLOTS = kmhrb_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       operation,
  input  logic [2:0]                       row,
  input  logic [3:0]                       column,
  input  logic [kmhrb_pkg::CODE_W-1:0]     keycode,
  input  logic [kmhrb_pkg::LEVELS_W-1:0]   column_levels,
  output logic                             done,
  output logic [kmhrb_pkg::CODE_W-1:0]     modifier_bits,
  output logic [kmhrb_pkg::CODE_W-1:0]     slot_0,
  output logic [kmhrb_pkg::CODE_W-1:0]     slot_1,
  output logic [kmhrb_pkg::CODE_W-1:0]     slot_2,
  output logic [kmhrb_pkg::CODE_W-1:0]     slot_3,
  output logic [kmhrb_pkg::CODE_W-1:0]     slot_4,
  output logic [kmhrb_pkg::CODE_W-1:0]     slot_5
);
  import kmhrb_pkg::*;

  localparam int NKEYS   = ROWS * COLS;
  localparam int KEY_W   = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int CLR_LEN = (NKEYS > EDGE_DEPTH) ? NKEYS : EDGE_DEPTH;
  localparam int UPD_LEN = 2 * EDGE_DEPTH;
  localparam int CNT_W   = (CLR_LEN > UPD_LEN) ? $clog2(CLR_LEN) : $clog2(UPD_LEN);

  state_t state, state_next;

  logic [CNT_W-1:0]    cnt;
  logic                clr_all;
  logic [KEY_W-1:0]    key_q;
  logic [LEVELS_W-1:0] levels_q;
  logic                chk_vld;
  logic                chk_pass;
  logic [EDGE_W-1:0]   chk_code;

  logic [1:0]          hist_mem [NKEYS];
  logic [CODE_W-1:0]   map_mem  [NKEYS];
  logic [1:0]          edge_mem [EDGE_DEPTH];
  logic [1:0]          hist_rd;
  logic [CODE_W-1:0]   map_rd;
  logic [1:0]          edge_rd;

  logic                accept;
  op_t                 op;
  logic                row_ok;
  logic                col_ok;
  logic [KEY_W-1:0]    load_idx;
  logic [KEY_W-1:0]    row_base;
  logic [1:0]          hist_new;
  logic                clr_last;
  logic                scan_last;
  logic                upd_last;

  slot_cmd_t                    cmd;
  logic [CODE_W-1:0]            mods;
  logic [SLOTS-1:0][CODE_W-1:0] slots;
  logic                         changed;
  logic [CODE_W-1:0]            slot_out [OUT_SLOTS];

  assign accept   = start && !busy;
  assign op       = op_t'(operation);
  assign row_ok   = 32'(row) < ROWS;
  assign col_ok   = 32'(column) < COLS;
  assign row_base = KEY_W'(32'(row) * 32'(COLS));
  assign load_idx = KEY_W'(32'(row) * 32'(COLS) + 32'(column));
  assign hist_new = {hist_rd[0], levels_q[0]};

  assign clr_last  = clr_all ? (cnt == CNT_W'(CLR_LEN - 1)) : (cnt == CNT_W'(EDGE_DEPTH - 1));
  assign scan_last = cnt == CNT_W'(COLS - 1);
  assign upd_last  = cnt == CNT_W'(UPD_LEN - 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD:   state_next = ST_IDLE;
            OP_SCAN:   state_next = row_ok ? ST_SCAN_RD : ST_IDLE;
            OP_UPDATE: state_next = ST_UPD;
            OP_CLEAR:  state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:   state_next = clr_last ? ST_IDLE : ST_CLEAR;
      ST_SCAN_RD: state_next = ST_SCAN_WR;
      ST_SCAN_WR: state_next = scan_last ? ST_IDLE : ST_SCAN_RD;
      ST_UPD:     state_next = upd_last ? ST_DRAIN : ST_UPD;
      ST_DRAIN:   state_next = ST_REPORT;
      ST_REPORT:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = state != ST_IDLE;
    done      = (state == ST_REPORT) && changed;
    cmd.clr   = accept && (op == OP_UPDATE);
    cmd.vld   = chk_vld &&
                (chk_pass ? (edge_rd == EDGE_PRESS) : (edge_rd == EDGE_RELEASE));
    cmd.press = chk_pass;
    cmd.code  = chk_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      cnt     <= '0;
      clr_all <= 1'b1;
      chk_vld <= 1'b0;
    end else begin
      state   <= state_next;
      chk_vld <= state == ST_UPD;
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept && op == OP_CLEAR) begin
            clr_all <= 1'b0;
          end
        end
        ST_CLEAR, ST_SCAN_WR, ST_UPD: cnt <= cnt + 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && op == OP_SCAN) begin
      key_q    <= row_base;
      levels_q <= column_levels;
    end else if (state == ST_SCAN_WR) begin
      key_q    <= key_q + 1'b1;
      levels_q <= levels_q >> 1;
    end
    chk_pass <= cnt[EDGE_W];
    chk_code <= cnt[EDGE_W-1:0];
  end

  // key history memory
  always_ff @(posedge clk) begin
    if (state == ST_SCAN_WR) begin
      hist_mem[key_q] <= hist_new;
    end else if (state == ST_CLEAR && clr_all && 32'(cnt) < NKEYS) begin
      hist_mem[cnt[KEY_W-1:0]] <= EDGE_NONE;
    end
    hist_rd <= hist_mem[key_q];
  end

  // keymap memory
  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD && row_ok && col_ok) begin
      map_mem[load_idx] <= keycode;
    end
    map_rd <= map_mem[key_q];
  end

  // edge list memory
  always_ff @(posedge clk) begin
    if (state == ST_SCAN_WR) begin
      if (hist_new == EDGE_PRESS || hist_new == EDGE_RELEASE) begin
        edge_mem[map_rd] <= hist_new;
      end
    end else if (state == ST_CLEAR && 32'(cnt) < EDGE_DEPTH) begin
      edge_mem[cnt[EDGE_W-1:0]] <= EDGE_NONE;
    end
    edge_rd <= edge_mem[cnt[EDGE_W-1:0]];
  end

  kmhrb_slots #(
    .SLOTS(SLOTS)
  ) u_slots (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .modifiers(mods),
    .slots    (slots),
    .changed  (changed)
  );

  for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_slot_out
    if (j < SLOTS) begin : g_used
      assign slot_out[j] = slots[j];
    end else begin : g_unused
      assign slot_out[j] = '0;
    end
  end

  assign modifier_bits = mods;
  assign slot_0 = slot_out[0];
  assign slot_1 = slot_out[1];
  assign slot_2 = slot_out[2];
  assign slot_3 = slot_out[3];
  assign slot_4 = slot_out[4];
  assign slot_5 = slot_out[5];

endmodule

// ----- rtl/kmhrb_slots.sv -----
// report slot table and modifier byte, one press or release applied per cycle
module kmhrb_slots #(
  parameter int SLOTS = kmhrb_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  kmhrb_pkg::slot_cmd_t                cmd,
  output logic [kmhrb_pkg::CODE_W-1:0]        modifiers,
  output logic [SLOTS-1:0][kmhrb_pkg::CODE_W-1:0] slots,
  output logic                                changed
);
  import kmhrb_pkg::*;

  logic [CODE_W-1:0]             modifiers_next;
  logic [SLOTS-1:0][CODE_W-1:0]  slots_next;
  logic                          hit;
  logic                          found;

  always_comb begin
    modifiers_next = modifiers;
    slots_next     = slots;
    hit            = 1'b0;
    found          = 1'b0;
    if (cmd.vld) begin
      if (cmd.press) begin
        if (cmd.code[CODE_W-1:3] == MOD_PREFIX) begin
          modifiers_next[cmd.code[2:0]] = 1'b1;
        end
        // first free slot takes the code, a full report drops it
        for (int j = 0; j < SLOTS; j++) begin
          if (!found && slots[j] == '0) begin
            slots_next[j] = cmd.code;
            found         = 1'b1;
            hit           = 1'b1;
          end
        end
      end else begin
        if (cmd.code[CODE_W-1:3] == MOD_PREFIX) begin
          modifiers_next[cmd.code[2:0]] = 1'b0;
        end
        // every slot holding the code is emptied
        for (int j = 0; j < SLOTS; j++) begin
          if (slots[j] == cmd.code) begin
            slots_next[j] = '0;
            hit           = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modifiers <= '0;
      slots     <= '0;
      changed   <= 1'b0;
    end else begin
      modifiers <= modifiers_next;
      slots     <= slots_next;
      changed   <= cmd.clr ? 1'b0 : (changed | hit);
    end
  end

endmodule
